>>> rtl/ucrr_pkg.sv
// ----------------------------------------------------------------------------
// ucrr_pkg
// types, codes and descriptor tables of the endpoint-zero responder
// ----------------------------------------------------------------------------
package ucrr_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] value_word;
    logic [15:0] index_word;
    logic [15:0] length_word;
  } req_t;

  typedef struct packed {
    logic [1:0] handshake;
    logic [6:0] packet_length;
    logic [7:0] data_byte;
    logic       last;
    logic       address_update;
    logic [6:0] device_address;
    logic       clear_toggles;
  } rsp_t;

  typedef enum logic [1:0] {
    HS_IN    = 2'd0,
    HS_STALL = 2'd1,
    HS_NAK   = 2'd2,
    HS_NONE  = 2'd3
  } hs_e;

  typedef enum logic [1:0] {
    KIND_SETUP = 2'd0,
    KIND_IN    = 2'd1,
    KIND_RESET = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_VENDOR = 2'd0,
    REG_PRODUCT = 2'd1,
    REG_SELFPWR = 2'd2,
    REG_MAXPWR = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    PH_DEFAULT = 2'd0,
    PH_ADDRESSED = 2'd1,
    PH_CONFIGURED = 2'd2
  } phase_e;

  // byte source of a job
  typedef enum logic [1:0] {
    SRC_DEV = 2'd0,
    SRC_CFG = 2'd1,
    SRC_SHORT = 2'd2
  } src_e;

  typedef enum logic [0:0] {
    BK_IDLE = 1'b0,
    BK_SEND = 1'b1
  } bk_state_e;

  localparam logic [7:0] REQ_GET_STATUS  = 8'h00;
  localparam logic [7:0] REQ_CLR_FEATURE = 8'h01;
  localparam logic [7:0] REQ_SET_FEATURE = 8'h03;
  localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
  localparam logic [7:0] REQ_GET_DESC    = 8'h06;
  localparam logic [7:0] REQ_SET_DESC    = 8'h07;
  localparam logic [7:0] REQ_GET_CONFIG  = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;
  localparam logic [7:0] REQ_GET_IFACE   = 8'h0A;
  localparam logic [7:0] REQ_SET_IFACE   = 8'h0B;
  localparam logic [7:0] REQ_SYNCH_FRAME = 8'h0C;

  localparam logic [7:0] DT_DEVICE    = 8'h01;
  localparam logic [7:0] DT_CONFIG    = 8'h02;
  localparam logic [7:0] DT_QUALIFIER = 8'h06;

  localparam logic [3:0] RCP_DEVICE = 4'd0;
  localparam logic [3:0] RCP_IFACE  = 4'd1;
  localparam logic [3:0] RCP_EP     = 4'd2;

  localparam logic [5:0] DEV_DESC_LEN = 6'd18;
  localparam logic [5:0] CFG_DESC_LEN = 6'd32;

  // back end job: one packet or single handshake
  typedef struct packed {
    src_e       src;
    logic [1:0] hs;
    logic [6:0] count;      // bytes, 0 for a single result
    logic [5:0] start;      // first descriptor byte
    logic [7:0] b0;
    logic       addr;
    logic [6:0] address;
    logic       clr;
  } job_t;

  function automatic logic [7:0] dev_byte(input logic [5:0] i, input logic [6:0] mp,
                                          input logic [15:0] vid, input logic [15:0] pid);
    logic [7:0] b;
    b = 8'h00;
    case (i)
      6'd0: b = 8'd18;
      6'd1: b = 8'h01;
      6'd3: b = 8'h02;
      6'd7: b = {1'b0, mp};
      6'd8: b = vid[7:0];
      6'd9: b = vid[15:8];
      6'd10: b = pid[7:0];
      6'd11: b = pid[15:8];
      6'd12: b = 8'h01;
      6'd17: b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] cfg_byte(input logic [5:0] i, input logic [7:0] mpw);
    logic [7:0] b;
    b = 8'h00;
    case (i)
      6'd0: b = 8'd9;
      6'd1: b = 8'h02;
      6'd2: b = 8'd32;
      6'd4, 6'd5: b = 8'd1;
      6'd7: b = 8'h80;
      6'd8: b = mpw;
      6'd9: b = 8'd9;
      6'd10: b = 8'd4;
      6'd13: b = 8'd2;
      6'd14: b = 8'h0A;
      6'd18, 6'd25: b = 8'd7;
      6'd19, 6'd26: b = 8'd5;
      6'd20: b = 8'h81;
      6'd27: b = 8'h01;
      6'd21, 6'd28: b = 8'd3;
      6'd22, 6'd29: b = 8'd64;
      6'd24, 6'd31: b = 8'hFF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/ucrr_front.sv
// ----------------------------------------------------------------------------
// ucrr_front
// decodes requests, keeps device state and issues back end jobs
// ----------------------------------------------------------------------------
module ucrr_front import ucrr_pkg::*; #(
  parameter int MAX_PACKET = 64,
  parameter int EP_COUNT   = 2,
  parameter int IF_COUNT   = 1
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  req_t       req_i,
  input  logic       self_powered_i,
  output logic       job_valid_o,
  output job_t       job_o
);

  localparam logic [6:0] MaxPkt = 7'(MAX_PACKET);
  localparam int EpIdxW = (EP_COUNT > 1) ? $clog2(EP_COUNT) : 1;

  logic [1:0]          phase_q, phase_d;
  logic                config_q, config_d;
  logic [EP_COUNT-1:0] halt_q, halt_d;
  logic [7:0]          last_code_q, last_code_d;
  logic [6:0]          pend_addr_q, pend_addr_d;
  logic [5:0]          total_q, total_d;
  logic [5:0]          sent_q, sent_d;
  logic                xsrc_q, xsrc_d;
  job_t                job;

  logic              live, if_ok, ep_ok;
  logic [7:0]        code, dtype;
  logic [15:0]       wlen, val, idx;
  logic [EpIdxW-1:0] ep;
  logic [5:0]        rem;
  logic [6:0]        chunk;
  logic [5:0]        size;

  always_comb begin
    code  = req_i.request_code;
    val   = req_i.value_word;
    idx   = req_i.index_word;
    wlen  = req_i.length_word;
    dtype = val[15:8];
    ep    = idx[EpIdxW-1:0];
    live  = (phase_q == PH_ADDRESSED) || (phase_q == PH_CONFIGURED);
    if_ok = (phase_q == PH_CONFIGURED) && (idx < 16'(IF_COUNT));
    ep_ok = ((phase_q == PH_CONFIGURED) || (phase_q == PH_ADDRESSED && idx == 16'd0))
            && (idx < 16'(EP_COUNT)) && (val == 16'd0);
    phase_d = phase_q; config_d = config_q; halt_d = halt_q;
    last_code_d = last_code_q; pend_addr_d = pend_addr_q;
    total_d = total_q; sent_d = sent_q; xsrc_d = xsrc_q;
    size = 6'd0; rem = 6'd0; chunk = 7'd0;
    job = '0;
    job.src = SRC_SHORT;
    job.hs = HS_NONE;
    if (req_valid_i) begin
      unique case (req_i.req_type)
        KIND_SETUP: begin
          last_code_d = code;
          pend_addr_d = val[6:0];
          total_d = 6'd0; sent_d = 6'd0;
          unique case (req_i.request_type[3:0])
            RCP_DEVICE: begin
              unique case (code)
                REQ_GET_STATUS: begin
                  job.hs = HS_IN; job.b0 = {7'd0, self_powered_i};
                  job.count = (wlen < 16'd2) ? wlen[6:0] : 7'd2;
                end
                REQ_SET_FEATURE, REQ_SET_ADDRESS: job.hs = HS_IN;
                REQ_CLR_FEATURE, REQ_SET_DESC: job.hs = HS_STALL;
                REQ_GET_DESC: begin
                  if (dtype == DT_DEVICE || dtype == DT_CONFIG) begin
                    size = (dtype == DT_DEVICE) ? DEV_DESC_LEN : CFG_DESC_LEN;
                    xsrc_d = (dtype == DT_CONFIG);
                    total_d = (wlen < 16'(size)) ? wlen[5:0] : size;
                    chunk = (7'(total_d) > MaxPkt) ? MaxPkt : 7'(total_d);
                    sent_d = 6'(chunk);
                    job.hs = HS_IN; job.count = chunk;
                    job.src = (dtype == DT_CONFIG) ? SRC_CFG : SRC_DEV;
                  end else if (dtype == DT_QUALIFIER) begin
                    job.hs = HS_STALL;
                  end
                end
                REQ_GET_CONFIG: begin
                  if (!live) job.hs = HS_STALL;
                  else begin
                    if (phase_q == PH_ADDRESSED) config_d = 1'b0;
                    job.hs = HS_IN; job.b0 = {7'd0, config_d};
                    job.count = (wlen == 16'd0) ? 7'd0 : 7'd1;
                  end
                end
                REQ_SET_CONFIG: begin
                  if (!live || val[7:1] != 7'd0) job.hs = HS_STALL;
                  else begin
                    job.hs = HS_IN;
                    config_d = val[0];
                    phase_d = val[0] ? PH_CONFIGURED : PH_ADDRESSED;
                    job.clr = val[0];
                  end
                end
                default: job.hs = HS_NONE;
              endcase
            end
            RCP_IFACE: begin
              unique case (code)
                REQ_GET_STATUS: begin
                  job.hs = if_ok ? HS_IN : HS_STALL;
                  job.count = (!if_ok) ? 7'd0 : (wlen < 16'd2) ? wlen[6:0] : 7'd2;
                end
                REQ_CLR_FEATURE, REQ_SET_FEATURE: job.hs = HS_STALL;
                REQ_GET_IFACE: begin
                  job.hs = if_ok ? HS_IN : HS_STALL;
                  job.count = (if_ok && wlen != 16'd0) ? 7'd1 : 7'd0;
                end
                REQ_SET_IFACE: job.hs = if_ok ? HS_IN : HS_STALL;
                default: job.hs = HS_NONE;
              endcase
            end
            RCP_EP: begin
              unique case (code)
                REQ_GET_STATUS: begin
                  job.hs = ep_ok ? HS_IN : HS_STALL;
                  job.count = (!ep_ok) ? 7'd0 : (wlen < 16'd2) ? wlen[6:0] : 7'd2;
                  // endpoint number is in range whenever ep_ok holds
                  if (ep_ok) job.b0 = {7'd0, halt_q[ep]};
                end
                REQ_CLR_FEATURE, REQ_SET_FEATURE: begin
                  job.hs = ep_ok ? HS_IN : HS_STALL;
                  if (ep_ok) halt_d[ep] = (code == REQ_SET_FEATURE);
                end
                REQ_SYNCH_FRAME: job.hs = HS_STALL;
                default: job.hs = HS_NONE;
              endcase
            end
            default: job.hs = HS_NONE;
          endcase
        end
        KIND_IN: begin
          if (last_code_q == REQ_SET_ADDRESS) begin
            job.addr = 1'b1; job.address = pend_addr_q;
            phase_d = (pend_addr_q != 7'd0) ? PH_ADDRESSED : PH_DEFAULT;
          end
          if (total_q > sent_q) begin
            rem = total_q - sent_q;
            chunk = (7'(rem) > MaxPkt) ? MaxPkt : 7'(rem);
            job.hs = HS_IN; job.count = chunk; job.start = sent_q;
            job.src = xsrc_q ? SRC_CFG : SRC_DEV;
            sent_d = 6'(7'(sent_q) + chunk);
          end
        end
        KIND_RESET: begin
          phase_d = PH_DEFAULT; config_d = 1'b0; last_code_d = 8'd0;
          pend_addr_d = 7'd0; total_d = 6'd0; sent_d = 6'd0; xsrc_d = 1'b0;
          halt_d = '0;
          job.hs = HS_NAK; job.addr = 1'b1; job.clr = 1'b1;
        end
        default: job.hs = HS_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DEFAULT; config_q <= 1'b0; halt_q <= '0;
      last_code_q <= 8'd0; pend_addr_q <= 7'd0; total_q <= 6'd0;
      sent_q <= 6'd0; xsrc_q <= 1'b0; job_valid_o <= 1'b0;
    end else begin
      phase_q <= phase_d; config_q <= config_d; halt_q <= halt_d;
      last_code_q <= last_code_d; pend_addr_q <= pend_addr_d; total_q <= total_d;
      sent_q <= sent_d; xsrc_q <= xsrc_d; job_valid_o <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i) job_o <= job;
  end

endmodule

>>> rtl/ucrr_back.sv
// ----------------------------------------------------------------------------
// ucrr_back
// streams one job out as a packet of result bytes
// ----------------------------------------------------------------------------
module ucrr_back import ucrr_pkg::*; #(
  parameter int MAX_PACKET = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  input  logic [15:0] vendor_id_i,
  input  logic [15:0] product_id_i,
  input  logic [7:0]  max_power_i,
  output logic        rsp_valid_o,
  output rsp_t        rsp_o
);

  bk_state_e  state_q, state_d;
  job_t       job_q, job_d;
  logic [6:0] pos_q, pos_d;
  logic       rv_d;
  rsp_t       rsp_d;
  logic [5:0] addr;
  logic [6:0] mp;

  assign mp = 7'(MAX_PACKET);

  always_comb begin
    state_d = state_q; job_d = job_q; pos_d = pos_q;
    rv_d = 1'b0; rsp_d = '0;
    addr = 6'(7'(job_q.start) + pos_q);
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          job_d = job_i; pos_d = 7'd0; state_d = BK_SEND;
        end
      end
      BK_SEND: begin
        rv_d = 1'b1;
        rsp_d.handshake = job_q.hs;
        rsp_d.packet_length = job_q.count;
        rsp_d.address_update = job_q.addr;
        rsp_d.device_address = job_q.address;
        rsp_d.clear_toggles = job_q.clr;
        if (job_q.count != 7'd0) begin
          case (job_q.src)
            SRC_DEV: rsp_d.data_byte = dev_byte(addr, mp, vendor_id_i, product_id_i);
            SRC_CFG: rsp_d.data_byte = cfg_byte(addr, max_power_i);
            default: rsp_d.data_byte = (pos_q == 7'd0) ? job_q.b0 : 8'd0;
          endcase
        end
        if (pos_q + 7'd1 >= job_q.count) begin
          rsp_d.last = 1'b1; state_d = BK_IDLE;
        end
        pos_d = pos_q + 7'd1;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE; rsp_valid_o <= 1'b0;
    end else begin
      state_q <= state_d; rsp_valid_o <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d; pos_q <= pos_d; rsp_o <= rsp_d;
  end

endmodule

>>> rtl/usb_control_request_responder.sv
// ----------------------------------------------------------------------------
// usb_control_request_responder
// endpoint-zero responder for standard usb requests
// ----------------------------------------------------------------------------
// a request passes the front job register, the back end job register and the
// response register; n results (up to MAX_PACKET, or one for a job with no
// data) then follow at one result per cycle from the one-byte-per-cycle back
// end; busy holds while an item is in flight, and results cannot be held off
// reset clears device state and registers back to their defaults
module usb_control_request_responder import ucrr_pkg::*; #(
  parameter int MAX_PACKET = 64,
  parameter int EP_COUNT   = 2,
  parameter int IF_COUNT   = 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        strobe,
  output rsp_t        rsp_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] vendor_q, product_q;
  logic        selfpwr_q;
  logic [7:0]  maxpwr_q;
  logic        job_valid, accept, inflight_q;
  job_t        job;

  // one request at a time: busy from accept until last result
  assign busy = inflight_q;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 1'b0;
    end else if (accept) begin
      inflight_q <= 1'b1;
    end else if (strobe && rsp_o.last) begin
      inflight_q <= 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vendor_q <= 16'h0483; product_q <= 16'h5740;
      selfpwr_q <= 1'b0; maxpwr_q <= 8'd50;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VENDOR: vendor_q <= cfg_data_i;
        REG_PRODUCT: product_q <= cfg_data_i;
        REG_SELFPWR: selfpwr_q <= cfg_data_i[0];
        REG_MAXPWR: maxpwr_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  ucrr_front #(
    .MAX_PACKET(MAX_PACKET), .EP_COUNT(EP_COUNT),
    .IF_COUNT(IF_COUNT)
  ) u_front (
    .clk_i, .rst_ni, .req_valid_i(accept), .req_i,
    .self_powered_i(selfpwr_q), .job_valid_o(job_valid), .job_o(job)
  );

  // front issues at most one job per accepted request, back is idle then
  ucrr_back #(.MAX_PACKET(MAX_PACKET)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job),
    .vendor_id_i(vendor_q), .product_id_i(product_q), .max_power_i(maxpwr_q),
    .rsp_valid_o(strobe), .rsp_o
  );

endmodule

>>> rtl/ucrr_checker.sv
// ----------------------------------------------------------------------------
// ucrr_checker
// port level checks of the responder
// ----------------------------------------------------------------------------
module ucrr_checker import ucrr_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic strobe,
  input rsp_t rsp_o
);

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised");

  a_strobe_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> busy) else $error("result outside request");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && rsp_o.last |=> !busy) else $error("busy after last");

  a_len_only_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && rsp_o.handshake != HS_IN |-> rsp_o.packet_length == 7'd0)
    else $error("length on non-data result");

endmodule

bind usb_control_request_responder ucrr_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .strobe, .rsp_o
);

>>> tb/usb_control_request_responder_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// usb_control_request_responder_chk
// watches the request, response and register ports of the responder, keeps
// its own copy of the device state, predicts every response and compares
// ----------------------------------------------------------------------------
module usb_control_request_responder_chk import ucrr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  logic        strobe_i,
  input  rsp_t        rsp_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  localparam int MAX_PKT = 64;
  localparam int N_EP    = 2;
  localparam int N_IF    = 1;

  localparam logic [7:0] CFG_TAIL [0:22] = '{
    8'd9, 8'd4, 8'd0, 8'd0, 8'd2, 8'h0A, 8'd0, 8'd0, 8'd0,
    8'd7, 8'd5, 8'h81, 8'd3, 8'd64, 8'd0, 8'hFF,
    8'd7, 8'd5, 8'h01, 8'd3, 8'd64, 8'd0, 8'hFF};

  // register copies
  logic [15:0] vid, pid;
  logic        self_pwr;
  logic [7:0]  max_pwr;

  // device state copies
  logic [1:0]  phase;
  logic        cur_cfg;
  logic        halted [N_EP];
  logic [7:0]  last_code;
  logic [6:0]  pend_addr;
  logic [5:0]  xfer_total, xfer_sent;
  logic        xfer_cfg;

  rsp_t reply [MAX_PKT];
  int   reply_n;
  rsp_t expected_rsp [$];

  assign pending_o = expected_rsp.size();

  function automatic logic [7:0] desc_byte(input logic from_cfg, input logic [5:0] i);
    logic [7:0] b;
    b = 8'h00;
    if (!from_cfg) begin
      case (i)
        6'd0: b = 8'd18;
        6'd1: b = 8'h01;
        6'd3: b = 8'h02;
        6'd7: b = 8'(MAX_PKT);
        6'd8: b = vid[7:0];
        6'd9: b = vid[15:8];
        6'd10: b = pid[7:0];
        6'd11: b = pid[15:8];
        6'd12, 6'd17: b = 8'h01;
        default: b = 8'h00;
      endcase
    end else begin
      case (i)
        6'd0: b = 8'd9;
        6'd1: b = 8'h02;
        6'd2: b = 8'd32;
        6'd4, 6'd5: b = 8'd1;
        6'd7: b = 8'h80;
        6'd8: b = max_pwr;
        default: b = (i >= 6'd9) ? CFG_TAIL[5'(i - 6'd9)] : 8'h00;
      endcase
    end
    return b;
  endfunction

  task automatic add_reply(input logic [1:0] hs, input int len, input logic [7:0] b);
    rsp_t r;
    r = '0;
    r.handshake = hs;
    r.packet_length = len[6:0];
    r.data_byte = b;
    reply[reply_n] = r;
    reply_n++;
  endtask

  task automatic send_chunk();
    int n;
    n = int'(xfer_total) - int'(xfer_sent);
    if (n > MAX_PKT) n = MAX_PKT;
    for (int i = 0; i < n; i++) add_reply(HS_IN, n, desc_byte(xfer_cfg, xfer_sent + 6'(i)));
    xfer_sent = xfer_sent + 6'(n);
  endtask

  task automatic begin_xfer(input logic from_cfg, input int size, input int wlen);
    xfer_cfg = from_cfg;
    xfer_total = 6'((wlen < size) ? wlen : size);
    xfer_sent = '0;
    if (xfer_total == 0) add_reply(HS_IN, 0, 8'h00);
    else send_chunk();
  endtask

  task automatic short_reply(input int n, input logic [7:0] b0, input int wlen);
    if (wlen < n) n = wlen;
    if (n == 0) add_reply(HS_IN, 0, 8'h00);
    else begin
      add_reply(HS_IN, n, b0);
      if (n > 1) add_reply(HS_IN, n, 8'h00);
    end
  endtask

  // works out the responses of one accepted request and updates the state
  task automatic predict_responses(input req_t r);
    logic addr, clr, live, ok;
    int   wlen, idx;
    addr = 1'b0;
    clr = 1'b0;
    wlen = int'(r.length_word);
    idx = int'(r.index_word);
    reply_n = 0;
    case (r.req_type)
      KIND_SETUP: begin
        last_code = r.request_code;
        pend_addr = r.value_word[6:0];
        xfer_total = '0;
        xfer_sent = '0;
        case (r.request_type[3:0])
          RCP_DEVICE: begin
            live = (phase == PH_ADDRESSED) || (phase == PH_CONFIGURED);
            case (r.request_code)
              REQ_GET_STATUS: short_reply(2, {7'd0, self_pwr}, wlen);
              REQ_CLR_FEATURE, REQ_SET_DESC: add_reply(HS_STALL, 0, 8'h00);
              REQ_SET_FEATURE, REQ_SET_ADDRESS: add_reply(HS_IN, 0, 8'h00);
              REQ_GET_DESC: begin
                case (r.value_word[15:8])
                  DT_DEVICE: begin_xfer(1'b0, 18, wlen);
                  DT_CONFIG: begin_xfer(1'b1, 32, wlen);
                  DT_QUALIFIER: add_reply(HS_STALL, 0, 8'h00);
                  default: add_reply(HS_NONE, 0, 8'h00);
                endcase
              end
              REQ_GET_CONFIG: begin
                if (!live) add_reply(HS_STALL, 0, 8'h00);
                else begin
                  if (phase == PH_ADDRESSED) cur_cfg = 1'b0;
                  short_reply(1, {7'd0, cur_cfg}, wlen);
                end
              end
              REQ_SET_CONFIG: begin
                if (!live) add_reply(HS_STALL, 0, 8'h00);
                else if (r.value_word[7:0] == 8'd0) begin
                  phase = PH_ADDRESSED;
                  cur_cfg = 1'b0;
                  add_reply(HS_IN, 0, 8'h00);
                end else if (r.value_word[7:0] == 8'd1) begin
                  phase = PH_CONFIGURED;
                  cur_cfg = 1'b1;
                  clr = 1'b1;
                  add_reply(HS_IN, 0, 8'h00);
                end else add_reply(HS_STALL, 0, 8'h00);
              end
              default: add_reply(HS_NONE, 0, 8'h00);
            endcase
          end
          RCP_IFACE: begin
            ok = (phase == PH_CONFIGURED) && (idx < N_IF);
            case (r.request_code)
              REQ_GET_STATUS: if (ok) short_reply(2, 8'h00, wlen);
                              else add_reply(HS_STALL, 0, 8'h00);
              REQ_CLR_FEATURE, REQ_SET_FEATURE: add_reply(HS_STALL, 0, 8'h00);
              REQ_GET_IFACE: if (ok) short_reply(1, 8'h00, wlen);
                             else add_reply(HS_STALL, 0, 8'h00);
              REQ_SET_IFACE: add_reply(ok ? HS_IN : HS_STALL, 0, 8'h00);
              default: add_reply(HS_NONE, 0, 8'h00);
            endcase
          end
          RCP_EP: begin
            ok = ((phase == PH_CONFIGURED) || (phase == PH_ADDRESSED && idx == 0)) &&
                 (idx < N_EP) && (r.value_word == 16'd0);
            case (r.request_code)
              REQ_GET_STATUS: if (ok) short_reply(2, {7'd0, halted[idx]}, wlen);
                              else add_reply(HS_STALL, 0, 8'h00);
              REQ_CLR_FEATURE, REQ_SET_FEATURE: begin
                if (ok) begin
                  halted[idx] = (r.request_code == REQ_SET_FEATURE);
                  add_reply(HS_IN, 0, 8'h00);
                end else add_reply(HS_STALL, 0, 8'h00);
              end
              REQ_SYNCH_FRAME: add_reply(HS_STALL, 0, 8'h00);
              default: add_reply(HS_NONE, 0, 8'h00);
            endcase
          end
          default: add_reply(HS_NONE, 0, 8'h00);
        endcase
      end
      KIND_IN: begin
        if (last_code == REQ_SET_ADDRESS) begin
          addr = 1'b1;
          phase = (pend_addr != 0) ? PH_ADDRESSED : PH_DEFAULT;
        end
        if (xfer_total > xfer_sent) send_chunk();
        else add_reply(HS_NONE, 0, 8'h00);
      end
      KIND_RESET: begin
        phase = PH_DEFAULT;
        cur_cfg = 1'b0;
        last_code = '0;
        pend_addr = '0;
        xfer_total = '0;
        xfer_sent = '0;
        xfer_cfg = 1'b0;
        foreach (halted[e]) halted[e] = 1'b0;
        add_reply(HS_NAK, 0, 8'h00);
        reply[0].address_update = 1'b1;
        clr = 1'b1;
      end
      default: add_reply(HS_NONE, 0, 8'h00);
    endcase
    for (int k = 0; k < reply_n; k++) begin
      if (addr) begin
        reply[k].address_update = 1'b1;
        reply[k].device_address = pend_addr;
      end
      if (clr) reply[k].clear_toggles = 1'b1;
      reply[k].last = (k == reply_n - 1);
      expected_rsp.push_back(reply[k]);
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_r;
    if (!rst_ni) begin
      vid = 16'h0483;
      pid = 16'h5740;
      self_pwr = 1'b0;
      max_pwr = 8'd50;
      phase = PH_DEFAULT;
      cur_cfg = 1'b0;
      last_code = '0;
      pend_addr = '0;
      xfer_total = '0;
      xfer_sent = '0;
      xfer_cfg = 1'b0;
      foreach (halted[e]) halted[e] = 1'b0;
      expected_rsp.delete();
      errors_o = 0;
    end else begin
      // results are compared before a new request is predicted
      if (strobe_i) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected response %h, expected none", $time, rsp_i);
          errors_o++;
        end else begin
          exp_r = expected_rsp.pop_front();
          check_field("handshake", exp_r.handshake, rsp_i.handshake);
          check_field("packet_length", exp_r.packet_length, rsp_i.packet_length);
          check_field("data_byte", exp_r.data_byte, rsp_i.data_byte);
          check_field("last", exp_r.last, rsp_i.last);
          check_field("address_update", exp_r.address_update, rsp_i.address_update);
          check_field("device_address", exp_r.device_address, rsp_i.device_address);
          check_field("clear_toggles", exp_r.clear_toggles, rsp_i.clear_toggles);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_VENDOR: vid = cfg_data_i;
          REG_PRODUCT: pid = cfg_data_i;
          REG_SELFPWR: self_pwr = cfg_data_i[0];
          REG_MAXPWR: max_pwr = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) predict_responses(req_i);
    end
  end

endmodule

>>> tb/usb_control_request_responder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// usb_control_request_responder_tb
// drives directed and random usb control requests with register changes in
// between; a separate checker predicts and compares every response
// ----------------------------------------------------------------------------
module usb_control_request_responder_tb;
  import ucrr_pkg::*;

  localparam int  LIMIT_CYCLES = 200000;
  localparam int  RANDOM_REQS  = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        strobe;
  rsp_t        rsp_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_VENDOR;
  logic [15:0] cfg_data_i = '0;
  int          errors;
  int          pending;
  int          cycles = 0;

  always #6 clk_i = ~clk_i;

  usb_control_request_responder dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .strobe, .rsp_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  usb_control_request_responder_chk chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .req_i, .strobe_i(strobe),
    .rsp_i(rsp_o), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  // watchdog against a hung handshake
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("usb_control_request_responder regression: fail");
      $finish;
    end
  end

  // hands one request over and holds start until the block takes it;
  // start stays high when the next request follows with no gap
  task automatic send_request(input req_t r);
    int gap;
    req_i <= r;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // mostly short gaps, now and then a long one
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic setup_req(input logic [7:0] rtype, input logic [7:0] code,
                           input logic [15:0] val, input logic [15:0] idx,
                           input logic [15:0] len);
    req_t r;
    r.req_type = KIND_SETUP;
    r.request_type = rtype;
    r.request_code = code;
    r.value_word = val;
    r.index_word = idx;
    r.length_word = len;
    send_request(r);
  endtask

  // an IN completion with random leftover fields
  task automatic in_done();
    req_t r;
    r = req_t'(66'({$urandom, $urandom, $urandom}));
    r.req_type = KIND_IN;
    send_request(r);
  endtask

  task automatic bus_reset();
    req_t r;
    r = req_t'(66'({$urandom, $urandom, $urandom}));
    r.req_type = KIND_RESET;
    send_request(r);
  endtask

  // registers only change with nothing in flight
  task automatic write_reg(input reg_e idx, input logic [15:0] data);
    start <= 1'b0;
    @(posedge clk_i);
    while (busy || pending != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(input logic [15:0] v, input logic [15:0] p,
                           input logic s, input logic [7:0] m);
    write_reg(REG_VENDOR, v);
    write_reg(REG_PRODUCT, p);
    write_reg(REG_SELFPWR, {15'd0, s});
    write_reg(REG_MAXPWR, {8'd0, m});
  endtask

  function automatic logic [15:0] rand_len();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'($urandom_range(1, 3));
      2: return 16'hFFFF;
      default: return 16'($urandom_range(0, 40));
    endcase
  endfunction

  function automatic logic [15:0] rand_index();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'h0081;
      3: return 16'd2;
      default: return 16'($urandom);
    endcase
  endfunction

  // recipient in the low nibble, random high bits elsewhere
  function automatic logic [7:0] rand_rtype(input logic [3:0] rcp);
    logic [7:0] t;
    t = 8'($urandom);
    if ($urandom_range(0, 3) != 0) t[7:4] = {1'b1, 3'b000} & t[7:4];
    return {t[7:4], rcp};
  endfunction

  // one random well-formed sequence, or noise
  task automatic random_sequence();
    req_t r;
    logic [7:0] code;
    case ($urandom_range(0, 11))
      0, 1: begin
        // descriptor read followed by the chunk completions
        setup_req(rand_rtype(RCP_DEVICE), REQ_GET_DESC,
                  {($urandom_range(0, 3) == 0) ? 8'($urandom) :
                   (($urandom_range(0, 1) == 0) ? DT_DEVICE : DT_CONFIG), 8'($urandom)},
                  16'($urandom), rand_len());
        repeat ($urandom_range(1, 2)) in_done();
      end
      2: begin
        setup_req(rand_rtype(RCP_DEVICE), REQ_SET_ADDRESS,
                  ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom), 16'($urandom),
                  16'd0);
        in_done();
      end
      3: setup_req(rand_rtype(RCP_DEVICE), REQ_SET_CONFIG,
                   ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1)),
                   16'($urandom), 16'd0);
      4: begin
        code = ($urandom_range(0, 1) == 0) ? REQ_SET_FEATURE : REQ_CLR_FEATURE;
        if ($urandom_range(0, 2) == 0) code = REQ_GET_STATUS;
        if ($urandom_range(0, 5) == 0) code = REQ_SYNCH_FRAME;
        setup_req(rand_rtype(RCP_EP), code,
                  ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'd0,
                  rand_index(), rand_len());
      end
      5: begin
        case ($urandom_range(0, 4))
          0: code = REQ_GET_STATUS;
          1: code = REQ_GET_IFACE;
          2: code = REQ_SET_IFACE;
          3: code = REQ_SET_FEATURE;
          default: code = 8'($urandom);
        endcase
        setup_req(rand_rtype(RCP_IFACE), code, 16'($urandom), rand_index(), rand_len());
      end
      6: setup_req(rand_rtype(RCP_DEVICE),
                   ($urandom_range(0, 1) == 0) ? REQ_GET_STATUS : REQ_GET_CONFIG,
                   16'($urandom), 16'($urandom), rand_len());
      7: if ($urandom_range(0, 2) == 0) bus_reset(); else in_done();
      default: begin
        r = req_t'(66'({$urandom, $urandom, $urandom}));
        if ($urandom_range(0, 1) == 0) r.request_code = 8'($urandom_range(0, 12));
        send_request(r);
      end
    endcase
  endtask

  initial begin
    int issued;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register extremes: vendor and max power low, product and self-powered high
    write_all(16'h0000, 16'hFFFF, 1'b1, 8'h00);

    // directed: status, descriptor and configuration requests while still in the default state
    setup_req(8'h80, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0002);
    setup_req(8'h80, REQ_GET_DESC, {DT_DEVICE, 8'h00}, 16'h0000, 16'hFFFF);
    in_done();
    setup_req(8'h80, REQ_GET_DESC, {DT_CONFIG, 8'h00}, 16'h0000, 16'h0000);
    setup_req(8'h80, REQ_GET_DESC, {DT_QUALIFIER, 8'h00}, 16'h0000, 16'h0040);
    setup_req(8'h80, REQ_GET_DESC, 16'hFFFF, 16'hFFFF, 16'h0007);
    setup_req(8'h80, REQ_GET_CONFIG, 16'h0000, 16'h0000, 16'h0001);
    setup_req(8'h00, REQ_SET_CONFIG, 16'h0001, 16'h0000, 16'h0000);
    // address load, then configure
    setup_req(8'h00, REQ_SET_ADDRESS, 16'h007F, 16'h0000, 16'h0000);
    in_done();
    setup_req(8'h00, REQ_SET_CONFIG, 16'h0001, 16'h0000, 16'h0000);
    setup_req(8'h80, REQ_GET_CONFIG, 16'h0000, 16'h0000, 16'h0001);
    setup_req(8'h02, REQ_SET_FEATURE, 16'h0000, 16'h0001, 16'h0000);
    setup_req(8'h82, REQ_GET_STATUS, 16'h0000, 16'h0001, 16'h0002);
    setup_req(8'h82, REQ_GET_STATUS, 16'h0000, 16'h0081, 16'h0002);
    setup_req(8'h02, REQ_CLR_FEATURE, 16'h0000, 16'h0001, 16'h0000);
    setup_req(8'h02, REQ_SYNCH_FRAME, 16'h0000, 16'h0001, 16'h0002);
    setup_req(8'h81, REQ_GET_IFACE, 16'h0000, 16'h0000, 16'h0001);
    setup_req(8'h01, REQ_SET_IFACE, 16'h0000, 16'h0001, 16'h0000);
    setup_req(8'h01, REQ_CLR_FEATURE, 16'h0000, 16'h0000, 16'h0000);
    setup_req(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    setup_req(8'h00, REQ_SET_DESC, 16'h0000, 16'h0000, 16'h0000);
    send_request('{req_type: 2'd3, request_type: 8'hFF, request_code: 8'hFF,
                   value_word: 16'hFFFF, index_word: 16'hFFFF, length_word: 16'hFFFF});
    in_done();
    bus_reset();

    // register extremes: vendor and max power high, product and self-powered low
    write_all(16'hFFFF, 16'h0000, 1'b0, 8'hFF);
    issued = 0;
    while (issued < RANDOM_REQS) begin
      random_sequence();
      issued++;
      if (issued % 37 == 0)
        write_all(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)), 8'($urandom));
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (busy || pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("usb_control_request_responder regression: pass");
    end else begin
      $display("usb_control_request_responder regression: fail");
    end
    $finish;
  end

endmodule
